>>> rtl/slc_pkg.sv
// Shared types, codes and constants of the scanline layer compositor.
// Used by every module of the compositor; depends on nothing else.
package slc_pkg;

   // Default values of the top level parameters.
   localparam int LINE_WIDTH_DEF  = 1280;
   localparam int FRAME_LINES_DEF = 800;
   localparam int SCROLL_STEP_DEF = 1;

   // Field widths.
   localparam int PIXEL_X_W  = 11;
   localparam int LINE_Y_W   = 10;
   localparam int SOURCE_W   = 3;
   localparam int ADDR_W     = 20;
   localparam int SCROLL_W   = 11;
   localparam int IMG_LINE_W = 12;
   localparam int REM_W      = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   // Lines up to and including this one are left alone.
   localparam int TOP_LINES = 20;

   // Source codes.
   localparam logic [SOURCE_W-1:0] SRC_NONE   = 3'd0;
   localparam logic [SOURCE_W-1:0] SRC_WALL   = 3'd1;
   localparam logic [SOURCE_W-1:0] SRC_WINDOW = 3'd2;
   localparam logic [SOURCE_W-1:0] SRC_IMAGE  = 3'd3;
   localparam logic [SOURCE_W-1:0] SRC_PREV   = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_PANEL_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PANEL_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PANEL_W  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PANEL_H  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_Y = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_W = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_H = 3'd7;

   typedef struct packed {
      logic [10:0]        panel_x;
      logic [9:0]         panel_y;
      logic signed [11:0] panel_w;
      logic [9:0]         panel_h;
      logic [10:0]        window_x;
      logic [9:0]         window_y;
      logic [10:0]        window_w;
      logic [9:0]         window_h;
   } cfg_type;

   typedef struct packed {
      logic                 cmd;
      logic [PIXEL_X_W-1:0] pixel_x;
      logic [LINE_Y_W-1:0]  line_y;
   } item_type;

   // After decode: final source and address, except for image store hits,
   // which still carry the unreduced image line and the column offset.
   typedef struct packed {
      logic [SOURCE_W-1:0]   src;
      logic [ADDR_W-1:0]     addr;
      logic [IMG_LINE_W-1:0] img_line;
      logic [PIXEL_X_W-1:0]  col;
   } dec_type;

   // After the line reduction: image line is now below the frame height.
   typedef struct packed {
      logic [SOURCE_W-1:0]  src;
      logic [ADDR_W-1:0]    addr;
      logic [REM_W-1:0]     img_row;
      logic [PIXEL_X_W-1:0] col;
   } red_type;

   typedef struct packed {
      logic [SOURCE_W-1:0] src;
      logic [ADDR_W-1:0]   addr;
   } rsp_type;

endpackage

>>> rtl/slc_decode.sv
// Layer decode stage: window and panel hit tests, window address, image line.
// Depends on slc_pkg.
module slc_decode #(
   parameter int LINE_WIDTH = slc_pkg::LINE_WIDTH_DEF
) (
   input  slc_pkg::item_type                 item,
   input  slc_pkg::cfg_type                  cfg,
   input  logic [slc_pkg::SCROLL_W-1:0]      scroll_offset,
   input  logic                              even_field,
   output slc_pkg::dec_type                  dec
);
   import slc_pkg::*;

   logic        in_area;
   logic        win_hit;
   logic        dbl;
   logic        pan_hit;
   logic        same_field;
   logic [12:0] neg_w;
   logic [12:0] pan_w;
   logic [10:0] pan_h;
   logic [9:0]  dy_win;
   logic [10:0] dx_win;
   logic [9:0]  dy_pan;
   logic [10:0] dx_pan;
   logic [20:0] win_prod;
   logic [21:0] win_addr;
   logic [11:0] line_sum;

   assign in_area = (item.line_y > 10'(TOP_LINES)) &&
                    ({1'b0, item.pixel_x} < 12'(LINE_WIDTH));

   assign win_hit = (item.line_y >= cfg.window_y) &&
                    ({1'b0, item.line_y} < ({1'b0, cfg.window_y} + {1'b0, cfg.window_h})) &&
                    (item.pixel_x >= cfg.window_x) &&
                    ({1'b0, item.pixel_x} < ({1'b0, cfg.window_x} + {1'b0, cfg.window_w}));

   // A negative width shows its magnitude in source pixels, each twice.
   assign dbl   = cfg.panel_w[11];
   assign neg_w = 13'd0 - {cfg.panel_w[11], cfg.panel_w};
   assign pan_w = dbl ? {neg_w[11:0], 1'b0} : {1'b0, cfg.panel_w};
   assign pan_h = dbl ? {cfg.panel_h, 1'b0} : {1'b0, cfg.panel_h};

   // Right edge clipping needs no logic: the pixel is already left of it.
   assign pan_hit = (item.line_y >= cfg.panel_y) &&
                    ({2'b00, item.line_y} < ({2'b00, cfg.panel_y} + {1'b0, pan_h})) &&
                    ({1'b0, cfg.panel_x} < 12'(LINE_WIDTH)) &&
                    (item.pixel_x >= cfg.panel_x) &&
                    ({2'b00, item.pixel_x} < ({2'b00, cfg.panel_x} + pan_w));

   assign same_field = (even_field == ~item.line_y[0]);

   assign dy_win   = item.line_y - cfg.window_y;
   assign dx_win   = item.pixel_x - cfg.window_x;
   assign win_prod = {11'd0, dy_win} * {10'd0, cfg.window_w};
   assign win_addr = {1'b0, win_prod} + {11'd0, dx_win};

   assign dy_pan   = item.line_y - cfg.panel_y;
   assign dx_pan   = item.pixel_x - cfg.panel_x;
   assign line_sum = {2'b00, dy_pan} + {1'b0, scroll_offset};

   always_comb begin
      dec.src      = SRC_NONE;
      dec.addr     = '0;
      dec.img_line = dbl ? {1'b0, line_sum[11:1]} : line_sum;
      dec.col      = dbl ? {1'b0, dx_pan[10:1]} : dx_pan;
      if (!item.cmd && in_area) begin
         dec.src = SRC_WALL;
         if (win_hit) begin
            dec.src  = SRC_WINDOW;
            dec.addr = win_addr[19:0];
         end
         if (pan_hit) begin
            if (same_field) begin
               dec.src  = SRC_IMAGE;
               dec.addr = '0;
            end else begin
               dec.src  = SRC_PREV;
               dec.addr = {9'd0, item.pixel_x};
            end
         end
      end
   end

endmodule

>>> rtl/slc_line_mod.sv
// Image line reduction modulo the frame height by restoring subtract steps.
// Depends on slc_pkg.
module slc_line_mod #(
   parameter int FRAME_LINES = slc_pkg::FRAME_LINES_DEF
) (
   input  slc_pkg::dec_type dec,
   output slc_pkg::red_type red
);
   import slc_pkg::*;

   // Largest image line is the panel line span plus the largest scroll.
   localparam int LINE_MAX = 1023 + 2 * FRAME_LINES - 1;
   localparam int STEPS    = $clog2(LINE_MAX / FRAME_LINES + 1);

   logic [12:0] rem_v;

   always_comb begin
      rem_v = {1'b0, dec.img_line};
      for (int k = STEPS - 1; k >= 0; k--) begin
         if (rem_v >= 13'(FRAME_LINES << k)) begin
            rem_v = rem_v - 13'(FRAME_LINES << k);
         end
      end
      red.src     = dec.src;
      red.addr    = dec.addr;
      red.img_row = rem_v[REM_W-1:0];
      red.col     = dec.col;
   end

endmodule

>>> rtl/slc_addr.sv
// Image store address stage: row times line width plus column.
// Depends on slc_pkg.
module slc_addr #(
   parameter int LINE_WIDTH = slc_pkg::LINE_WIDTH_DEF
) (
   input  slc_pkg::red_type red,
   output slc_pkg::rsp_type rsp
);
   import slc_pkg::*;

   localparam logic [11:0] LW_C = 12'(LINE_WIDTH);

   logic [21:0] img_addr;

   assign img_addr = {12'd0, red.img_row} * {10'd0, LW_C} + {11'd0, red.col};

   always_comb begin
      rsp.src  = red.src;
      rsp.addr = (red.src == SRC_IMAGE) ? img_addr[19:0] : red.addr;
   end

endmodule

>>> rtl/scanline_layer_compositor_core.sv
// Scanline layer compositor: an accepted request beat moves through the input, decode and
// line reduction registers into the output register, from which its response is presented.
// Throughput is one beat per cycle through a four-register pipeline (input, decode,
// line reduction, output); only a withheld rsp_tready stalls it, once all four are full.
// Reset is synchronous, active high: it empties the pipeline, loads the
// configuration defaults, clears the scroll offset and selects the even field.
module scanline_layer_compositor_core #(
   parameter int LINE_WIDTH  = slc_pkg::LINE_WIDTH_DEF,
   parameter int FRAME_LINES = slc_pkg::FRAME_LINES_DEF,
   parameter int SCROLL_STEP = slc_pkg::SCROLL_STEP_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [23:0]                         req_tdata,  // pixel_x[10:0], line_y[20:11]
   input  logic [0:0]                          req_tuser,  // cmd[0]
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [23:0]                         rsp_tdata,  // read_address[19:0]
   output logic [slc_pkg::SOURCE_W-1:0]        rsp_tuser,  // source[2:0]
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [slc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [slc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import slc_pkg::*;

   // Configuration registers and frame state.
   cfg_type             cfg_ff, cfg_in;
   logic [SCROLL_W-1:0] scroll_ff, scroll_in;
   logic                even_ff, even_in;
   logic [11:0]         scroll_sum;

   // Pipeline valid bits and payloads.
   logic     v0_ff, v0_in, v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   item_type s0_ff, s0_in;
   dec_type  s1_ff, s1_in;
   red_type  s2_ff, s2_in;
   rsp_type  s3_ff, s3_in;

   dec_type  dec_out;
   red_type  red_out;
   rsp_type  adr_out;

   logic rdy0, rdy1, rdy2, rdy3;
   logic tick_go;

   // Each stage takes a new beat when it is empty or its contents move on,
   // so a waiting response never stops earlier stages that have room.
   assign rdy3 = !v3_ff || rsp_tready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign rdy0 = !v0_ff || rdy1;

   assign req_tready = rdy0;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = v3_ff;
   assign rsp_tuser  = s3_ff.src;
   assign rsp_tdata  = {4'd0, s3_ff.addr};

   // The frame state is read by the decode stage, so a frame tick takes effect
   // as it leaves the input register; beats ahead of it see the old state.
   assign tick_go = v0_ff && rdy1 && s0_ff.cmd;

   slc_decode #(
      .LINE_WIDTH (LINE_WIDTH)
   ) u_decode (
      .item          (s0_ff),
      .cfg           (cfg_ff),
      .scroll_offset (scroll_ff),
      .even_field    (even_ff),
      .dec           (dec_out)
   );

   slc_line_mod #(
      .FRAME_LINES (FRAME_LINES)
   ) u_line_mod (
      .dec (s1_ff),
      .red (red_out)
   );

   slc_addr #(
      .LINE_WIDTH (LINE_WIDTH)
   ) u_addr (
      .red (s2_ff),
      .rsp (adr_out)
   );

   // Scroll advances modulo twice the frame height; the step must be smaller than
   // that, which the block itself does not enforce, so one conditional subtract is enough.
   assign scroll_sum = {1'b0, scroll_ff} + 12'(SCROLL_STEP);

   always_comb begin
      scroll_in = scroll_ff;
      even_in   = even_ff;
      if (tick_go) begin
         even_in = !even_ff;
         if (scroll_sum >= 12'(2 * FRAME_LINES)) begin
            scroll_in = 11'(scroll_sum - 12'(2 * FRAME_LINES));
         end else begin
            scroll_in = scroll_sum[SCROLL_W-1:0];
         end
      end
   end

   // Configuration writes; only the low bits of the data are kept, but the panel width takes all 12.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_PANEL_X:  cfg_in.panel_x  = csr_data[10:0];
            REG_PANEL_Y:  cfg_in.panel_y  = csr_data[9:0];
            REG_PANEL_W:  cfg_in.panel_w  = csr_data;
            REG_PANEL_H:  cfg_in.panel_h  = csr_data[9:0];
            REG_WINDOW_X: cfg_in.window_x = csr_data[10:0];
            REG_WINDOW_Y: cfg_in.window_y = csr_data[9:0];
            REG_WINDOW_W: cfg_in.window_w = csr_data[10:0];
            REG_WINDOW_H: cfg_in.window_h = csr_data[9:0];
            default: begin
            end
         endcase
      end
   end

   // Pipeline advance.
   always_comb begin
      v0_in = v0_ff;
      v1_in = v1_ff;
      v2_in = v2_ff;
      v3_in = v3_ff;
      s0_in = s0_ff;
      s1_in = s1_ff;
      s2_in = s2_ff;
      s3_in = s3_ff;
      if (rdy0) begin
         v0_in         = req_tvalid;
         s0_in.cmd     = req_tuser[0];
         s0_in.pixel_x = req_tdata[10:0];
         s0_in.line_y  = req_tdata[20:11];
      end
      if (rdy1) begin
         v1_in = v0_ff;
         s1_in = dec_out;
      end
      if (rdy2) begin
         v2_in = v1_ff;
         s2_in = red_out;
      end
      if (rdy3) begin
         v3_in = v2_ff;
         s3_in = adr_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff            <= 1'b0;
         v1_ff            <= 1'b0;
         v2_ff            <= 1'b0;
         v3_ff            <= 1'b0;
         scroll_ff        <= '0;
         even_ff          <= 1'b1;
         cfg_ff.panel_x   <= 11'd900;
         cfg_ff.panel_y   <= 10'd0;
         cfg_ff.panel_w   <= 12'sd200;
         cfg_ff.panel_h   <= 10'd800;
         cfg_ff.window_x  <= 11'd0;
         cfg_ff.window_y  <= 10'd0;
         cfg_ff.window_w  <= 11'd0;
         cfg_ff.window_h  <= 10'd0;
      end else begin
         v0_ff     <= v0_in;
         v1_ff     <= v1_in;
         v2_ff     <= v2_in;
         v3_ff     <= v3_in;
         scroll_ff <= scroll_in;
         even_ff   <= even_in;
         cfg_ff    <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_ff <= s0_in;
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
   end

`ifndef SYNTHESIS
   // The scroll offset stays inside twice the frame height.
   a_scroll_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, scroll_ff} < 12'(2 * FRAME_LINES))
      else $error("scroll offset out of range");

   // A frame tick leaving the input register flips the field.
   a_field_toggle: assert property (@(posedge clock) disable iff (reset)
      tick_go |=> (even_ff != $past(even_ff)))
      else $error("frame tick did not toggle the field");

   // Untouched and wallpaper responses carry a zero address.
   a_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == SRC_NONE || rsp_tuser == SRC_WALL)) |-> (rsp_tdata == '0))
      else $error("nonzero address for untouched or wallpaper pixel");

   // Previous line reads stay inside one line.
   a_prev_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == SRC_PREV) |-> (rsp_tdata < 24'(LINE_WIDTH)))
      else $error("previous line address beyond the line");

   // Only defined source codes reach the response.
   a_src_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= SRC_PREV))
      else $error("undefined source code");
`endif

endmodule
